// ===== rtl/svalloc_pkg.sv =====
// Shared types and codes for the synth voice allocator.
// No dependencies; imported by svalloc_dp, svalloc_ctrl and the top level.
package svalloc_pkg;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_ALL_OFF  = 2'd2,
        OP_RETIRE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IGNORED        = 3'd0,
        ST_RETRIGGER      = 3'd1,
        ST_FREE           = 3'd2,
        ST_STOLE_RELEASED = 3'd3,
        ST_STOLE_HELD     = 3'd4,
        ST_DONE           = 3'd5
    } t_status;

    typedef struct packed {
        t_op        operation;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [3:0] voice_slot;
    } t_event;

    typedef struct packed {
        t_status    status;
        logic [3:0] assigned_voice;
        logic [4:0] changed_count;
        logic [4:0] active_count;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } t_dp_sts;

endpackage

// ===== rtl/svalloc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module svalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/svalloc_dp.sv =====
// Datapath of the voice allocator: voice marks, voice RAM, scan accumulators
// and the result register. Depends on svalloc_pkg and svalloc_ram.
module svalloc_dp
    import svalloc_pkg::*;
#(
    parameter int VOICES = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_event  i_event,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output logic    o_valid,
    output t_result o_result
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);
    localparam int DW = 7 + 7 + 32;

    typedef struct packed {
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [31:0] age;
    } t_vdata;

    // Control state
    logic [VOICES-1:0] r_active;
    logic [VOICES-1:0] r_released;
    logic [CW-1:0]     r_act_cnt;
    logic [31:0]       r_next_age;
    logic              r_valid;
    logic              r_rd_vld;

    // Item and scan payload
    t_event            r_evt;
    t_result           r_result;
    logic [VW-1:0]     r_addr;
    logic [VW-1:0]     r_rd_idx;
    logic              r_hit;
    logic [VW-1:0]     r_hit_idx;
    logic              r_free;
    logic [VW-1:0]     r_free_idx;
    logic              r_rel;
    logic [VW-1:0]     r_rel_idx;
    logic [31:0]       r_rel_age;
    logic              r_old;
    logic [VW-1:0]     r_old_idx;
    logic [31:0]       r_old_age;
    logic [CW-1:0]     r_changed;

    t_vdata            w_rd;
    t_vdata            w_wr;
    logic [DW-1:0]     w_rdata;
    logic              w_note_on;
    logic              w_match;
    logic [VW-1:0]     w_sel;
    t_status           w_status;
    logic              w_slot_ok;
    logic [VW-1:0]     w_slot;
    logic [31:0]       w_age_inc;
    logic [CW-1:0]     n_act_cnt;
    logic [CW-1:0]     w_changed;
    t_result           n_result;

    svalloc_ram #(
        .WIDTH (DW),
        .DEPTH (VOICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && w_note_on),
        .i_waddr (w_sel),
        .i_wdata (w_wr),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_rd      = t_vdata'(w_rdata);
    assign w_note_on = (r_evt.operation == OP_NOTE_ON) && (r_evt.velocity != 7'd0);
    assign w_match   = r_active[r_rd_idx] && (w_rd.note == r_evt.note);
    assign w_slot_ok = {3'd0, r_evt.voice_slot} < 7'(VOICES);
    assign w_slot    = VW'(r_evt.voice_slot);

    assign o_sts.need_scan = w_note_on || (r_evt.operation == OP_NOTE_OFF);
    assign o_sts.scan_last = (r_addr == VW'(VOICES - 1));

    // Wrap past all ones to 1, never to 0
    always_comb begin
        w_age_inc = r_next_age + 32'd1;
        if (w_age_inc == 32'd0) begin
            w_age_inc = 32'd1;
        end
    end

    // Pick the voice: retrigger, then free, then oldest released, then oldest
    always_comb begin
        if (r_hit) begin
            w_sel    = r_hit_idx;
            w_status = ST_RETRIGGER;
        end else if (r_free) begin
            w_sel    = r_free_idx;
            w_status = ST_FREE;
        end else if (r_rel) begin
            w_sel    = r_rel_idx;
            w_status = ST_STOLE_RELEASED;
        end else begin
            w_sel    = r_old_idx;
            w_status = ST_STOLE_HELD;
        end
    end

    assign w_wr.note     = r_evt.note;
    assign w_wr.velocity = r_evt.velocity;
    assign w_wr.age      = r_next_age;

    always_comb begin
        n_act_cnt = r_act_cnt;
        w_changed = '0;
        n_result.status         = ST_DONE;
        n_result.assigned_voice = 4'd0;
        unique case (r_evt.operation)
            OP_NOTE_ON: begin
                if (w_note_on) begin
                    n_result.status         = w_status;
                    n_result.assigned_voice = 4'(w_sel);
                    if (!r_hit && r_free) begin
                        n_act_cnt = r_act_cnt + CW'(1);
                    end
                end else begin
                    n_result.status = ST_IGNORED;
                end
            end
            OP_NOTE_OFF: begin
                w_changed = r_changed;
            end
            OP_ALL_OFF: begin
                w_changed = r_act_cnt;
            end
            OP_RETIRE: begin
                if (w_slot_ok && r_active[w_slot]) begin
                    w_changed = CW'(1);
                    n_act_cnt = r_act_cnt - CW'(1);
                end
            end
            default: begin
                n_result.status = ST_DONE;
            end
        endcase
        n_result.changed_count = (32'(w_changed) > 32'd31) ? 5'd31 : 5'(w_changed);
        n_result.active_count  = (32'(n_act_cnt) > 32'd31) ? 5'd31 : 5'(n_act_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_released <= '0;
            r_act_cnt  <= '0;
            r_next_age <= 32'd1;
            r_valid    <= 1'b0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_valid  <= i_cmd.commit;
            r_rd_vld <= i_cmd.scan;
            r_rd_idx <= r_addr;

            if (i_cmd.load) begin
                r_evt     <= i_event;
                r_addr    <= '0;
                r_hit     <= 1'b0;
                r_free    <= 1'b0;
                r_rel     <= 1'b0;
                r_old     <= 1'b0;
                r_changed <= '0;
            end

            if (i_cmd.scan) begin
                r_addr <= r_addr + VW'(1);
            end

            // Fold one voice into the accumulators
            if (r_rd_vld) begin
                if (!r_hit && w_match) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                end
                if (!r_free && !r_active[r_rd_idx]) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
                if (r_released[r_rd_idx] && (!r_rel || w_rd.age < r_rel_age)) begin
                    r_rel     <= 1'b1;
                    r_rel_idx <= r_rd_idx;
                    r_rel_age <= w_rd.age;
                end
                if (!r_old || w_rd.age < r_old_age) begin
                    r_old     <= 1'b1;
                    r_old_idx <= r_rd_idx;
                    r_old_age <= w_rd.age;
                end
                if ((r_evt.operation == OP_NOTE_OFF) && w_match) begin
                    r_released[r_rd_idx] <= 1'b1;
                    r_changed            <= r_changed + CW'(1);
                end
            end

            if (i_cmd.commit) begin
                r_result  <= n_result;
                r_act_cnt <= n_act_cnt;
                unique case (r_evt.operation)
                    OP_NOTE_ON: begin
                        if (w_note_on) begin
                            r_active[w_sel]   <= 1'b1;
                            r_released[w_sel] <= 1'b0;
                            r_next_age        <= w_age_inc;
                        end
                    end
                    OP_ALL_OFF: begin
                        r_released <= '1;
                    end
                    OP_RETIRE: begin
                        if (w_slot_ok) begin
                            r_active[w_slot]   <= 1'b0;
                            r_released[w_slot] <= 1'b0;
                        end
                    end
                    default: begin
                        r_next_age <= r_next_age;
                    end
                endcase
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_cnt_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_act_cnt) == $countones(r_active))
        else $error("active count out of step with active marks");

    a_age_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_age != 32'd0)
        else $error("age stamp reached zero");

    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result word held longer than one cycle");

    a_take_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && w_note_on) |=> r_active[$past(w_sel)] && !r_released[$past(w_sel)])
        else $error("note-on did not claim its voice");

endmodule

// ===== rtl/svalloc_ctrl.sv =====
// Controller state machine of the voice allocator: sequences load, scan,
// drain and commit. Depends on svalloc_pkg.
module svalloc_ctrl
    import svalloc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_sts.need_scan) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.scan = 1'b1;
                    if (i_sts.scan_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign busy = r_busy;

endmodule

// ===== rtl/synth_voice_allocator_core.sv =====
// Top level of the polyphonic voice allocator with oldest-voice stealing.
// Depends on svalloc_pkg, svalloc_ctrl, svalloc_dp (and svalloc_ram below it).
//
// Events: note-on with nonzero velocity and note-off scan the voice RAM one
//   entry a cycle; zero-velocity note-on, all-off and retire skip the scan.
//   One event at a time (single RAM read port): a new one is accepted only
//   once the controller is back in idle after the commit.
// Reset (synchronous, active low): clear active/released marks and the active
//   count, set the age stamp to 1. No clearing pass; RAM entries matter only once
//   written, since every voice has been rewritten before its data can count.
module synth_voice_allocator_core
    import svalloc_pkg::*;
#(
    parameter int VOICES = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_event  i_event,
    output logic    o_valid,
    output t_result o_result
);

    // Command and status between the sequencer and the voice datapath
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer: accept a word while idle, then scan, drain and commit
    svalloc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Voice table, selection accumulators and the result register; the
    // result word is held for exactly one cycle with o_valid high
    svalloc_dp #(
        .VOICES (VOICES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_event  (i_event),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
